[hdl/drbc_pkg.sv]
// Shared types and constants for the door relay / buzzer controller.
// Used by drbc_core, drbc_outq and door_relay_buzzer_controller; no dependencies.
`timescale 1ns / 1ps

package drbc_pkg;

	localparam int unsigned HOLD_W    = 24;
	localparam int unsigned PULSE_W   = 7;
	localparam int unsigned PHASE_W   = 8;
	localparam int unsigned MAX_RES   = 3;
	localparam int unsigned RIDX_W    = 2;

	typedef enum logic [3:0] {
		MODE_TICK        = 4'd0,
		MODE_RELAY_ON    = 4'd1,
		MODE_RELAY_OFF   = 4'd2,
		MODE_BUZZER_ON   = 4'd3,
		MODE_BUZZER_OFF  = 4'd4,
		MODE_ALARM_ON    = 4'd5,
		MODE_ALARM_OFF   = 4'd6,
		MODE_PANIC_ON    = 4'd7,
		MODE_PANIC_OFF   = 4'd8,
		MODE_BREAKIN_ON  = 4'd9,
		MODE_BREAKIN_OFF = 4'd10,
		MODE_BEEP        = 4'd11,
		MODE_SENSOR_EDGE = 4'd12,
		MODE_QR_ON       = 4'd13,
		MODE_QR_OFF      = 4'd14
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SENSOR = 2'd1,
		EV_RELAY  = 2'd2,
		EV_BUZZER = 2'd3
	} event_t;

	typedef struct packed {
		logic relay;
		logic buzzer;
		logic qrcode;
		logic alarm;
		logic panic;
		logic breakin;
		logic sensor;
	} status_t;

	typedef struct packed {
		event_t  kind;
		logic    value;
		status_t status;
	} result_t;

	// Up to three results produced by one request; count is 1..3.
	typedef struct packed {
		logic [RIDX_W-1:0]          count;
		result_t [MAX_RES-1:0]      slot;
	} bundle_t;

	function automatic result_t make_result(event_t kind, logic value, status_t st);
		result_t r;
		r.kind   = kind;
		r.value  = value;
		r.status = st;
		return r;
	endfunction

endpackage

[hdl/drbc_core.sv]
// Controller state and the single-pass next-state / result logic for one request.
// Depends on drbc_pkg.
`timescale 1ns / 1ps

module drbc_core #(
	parameter int unsigned TICK_MS       = 100,
	parameter int unsigned BEEP_HALF_MS  = 100,
	parameter int unsigned DEFAULT_BEEPS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            commit,
	input  logic                            sensor_mode,
	input  logic [3:0]                      mode,
	input  logic [drbc_pkg::HOLD_W-1:0]     hold_ms,
	input  logic [drbc_pkg::PULSE_W-1:0]    beep_pulses,
	input  logic                            sensor_sample,
	output drbc_pkg::bundle_t               bundle
);

	localparam logic [drbc_pkg::HOLD_W-1:0]  TICK_W    = drbc_pkg::HOLD_W'(TICK_MS);
	localparam logic [drbc_pkg::HOLD_W-1:0]  BEEP_W    = drbc_pkg::HOLD_W'(BEEP_HALF_MS);
	localparam logic [drbc_pkg::PULSE_W-1:0] DEF_BEEPS = drbc_pkg::PULSE_W'(DEFAULT_BEEPS);

	drbc_pkg::status_t              status_q, st;
	logic [drbc_pkg::HOLD_W-1:0]    relay_rem_q, buzzer_rem_q, beep_rem_q;
	logic [drbc_pkg::HOLD_W-1:0]    relay_rem, buzzer_rem, beep_rem;
	logic [drbc_pkg::PHASE_W-1:0]   phases_q, phases;
	logic [drbc_pkg::PULSE_W-1:0]   pulses_eff;
	logic [drbc_pkg::RIDX_W-1:0]    n;

	always_comb begin
		st         = status_q;
		relay_rem  = relay_rem_q;
		buzzer_rem = buzzer_rem_q;
		beep_rem   = beep_rem_q;
		phases     = phases_q;
		pulses_eff = (beep_pulses != '0) ? beep_pulses : DEF_BEEPS;
		n          = '0;
		bundle     = '0;
		case (drbc_pkg::mode_t'(mode))
			drbc_pkg::MODE_TICK: begin
				if (!sensor_mode && st.sensor != sensor_sample) begin
					st.sensor = sensor_sample;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_SENSOR,
						sensor_sample, st);
					n = n + 2'd1;
				end
				if (relay_rem != '0) begin
					relay_rem = (relay_rem > TICK_W) ? relay_rem - TICK_W : '0;
					if (relay_rem == '0) begin
						st.relay = 1'b0;
						bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_RELAY, 1'b0, st);
						n = n + 2'd1;
					end
				end
				if (buzzer_rem != '0) begin
					buzzer_rem = (buzzer_rem > TICK_W) ? buzzer_rem - TICK_W : '0;
					if (buzzer_rem == '0) begin
						st.buzzer = 1'b0;
						bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b0, st);
						n = n + 2'd1;
					end
				end
				// The beep generator toggles the buzzer silently.
				if (beep_rem != '0) begin
					beep_rem = (beep_rem > TICK_W) ? beep_rem - TICK_W : '0;
					if (beep_rem == '0) begin
						phases    = phases - 8'd1;
						st.buzzer = phases[0];
						if (phases != '0) begin
							beep_rem = BEEP_W;
						end
					end
				end
			end
			drbc_pkg::MODE_RELAY_ON: begin
				st.relay  = 1'b1;
				relay_rem = hold_ms;
				bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_RELAY, 1'b1, st);
				n = n + 2'd1;
			end
			drbc_pkg::MODE_RELAY_OFF: begin
				st.relay  = 1'b0;
				relay_rem = '0;
				bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_RELAY, 1'b0, st);
				n = n + 2'd1;
			end
			drbc_pkg::MODE_BUZZER_ON: begin
				st.buzzer  = 1'b1;
				buzzer_rem = hold_ms;
				bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b1, st);
				n = n + 2'd1;
			end
			drbc_pkg::MODE_BUZZER_OFF: begin
				st.buzzer  = 1'b0;
				buzzer_rem = '0;
				bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b0, st);
				n = n + 2'd1;
			end
			drbc_pkg::MODE_ALARM_ON: begin
				if (!st.alarm) begin
					st.alarm   = 1'b1;
					st.buzzer  = 1'b1;
					buzzer_rem = '0;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b1, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_ALARM_OFF: begin
				if (st.alarm) begin
					st.alarm   = 1'b0;
					st.breakin = 1'b0;
					st.buzzer  = 1'b0;
					buzzer_rem = '0;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b0, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_PANIC_ON: begin
				if (!st.panic) begin
					st.panic  = 1'b1;
					st.relay  = 1'b1;
					relay_rem = '0;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_RELAY, 1'b1, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_PANIC_OFF: begin
				if (st.panic) begin
					st.panic  = 1'b0;
					st.relay  = 1'b0;
					relay_rem = '0;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_RELAY, 1'b0, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_BREAKIN_ON: begin
				if (!st.breakin) begin
					st.breakin = 1'b1;
					st.alarm   = 1'b1;
					st.buzzer  = 1'b1;
					buzzer_rem = '0;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b1, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_BREAKIN_OFF: begin
				if (st.breakin) begin
					st.breakin = 1'b0;
					st.alarm   = 1'b0;
					st.buzzer  = 1'b0;
					buzzer_rem = '0;
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_BUZZER, 1'b0, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_BEEP: begin
				st.buzzer = 1'b1;
				beep_rem  = BEEP_W;
				phases    = {pulses_eff, 1'b0};
			end
			drbc_pkg::MODE_SENSOR_EDGE: begin
				if (sensor_mode) begin
					bundle.slot[n] = drbc_pkg::make_result(drbc_pkg::EV_SENSOR, 1'b0, st);
					n = n + 2'd1;
				end
			end
			drbc_pkg::MODE_QR_ON:  st.qrcode = 1'b1;
			drbc_pkg::MODE_QR_OFF: st.qrcode = 1'b0;
			default: ;
		endcase
		// A request that caused no event still reports the status once.
		if (n == '0) begin
			bundle.slot[0] = drbc_pkg::make_result(drbc_pkg::EV_NONE, 1'b0, st);
			n = 2'd1;
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= '0;
			relay_rem_q  <= '0;
			buzzer_rem_q <= '0;
			beep_rem_q   <= '0;
			phases_q     <= '0;
		end else if (commit) begin
			status_q     <= st;
			relay_rem_q  <= relay_rem;
			buzzer_rem_q <= buzzer_rem;
			beep_rem_q   <= beep_rem;
			phases_q     <= phases;
		end
	end

endmodule

[hdl/drbc_outq.sv]
// Result register: holds one request's result bundle and hands its results out in order.
// Depends on drbc_pkg.
`timescale 1ns / 1ps

module drbc_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	output logic                load_ready,
	input  drbc_pkg::bundle_t   load_bundle,
	output logic                out_valid,
	input  logic                out_ready,
	output drbc_pkg::result_t   out_result,
	output logic                out_last
);

	drbc_pkg::bundle_t              bundle_s2;
	logic                           valid_s2;
	logic [drbc_pkg::RIDX_W-1:0]    idx_q;
	logic                           take, drained;

	assign out_valid  = valid_s2;
	assign out_result = bundle_s2.slot[idx_q];
	assign out_last   = (idx_q == bundle_s2.count - 2'd1);
	assign take       = valid_s2 && out_ready;
	assign drained    = take && out_last;
	assign load_ready = !valid_s2 || drained;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load_valid && load_ready) begin
				valid_s2 <= 1'b1;
				idx_q    <= '0;
			end else if (drained) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			bundle_s2 <= load_bundle;
		end
	end

endmodule

[hdl/door_relay_buzzer_controller.sv]
// Door relay / buzzer / QR-reader output controller, top level.
// A request is registered in the input stage, then its results in the result register, which offers them.
// A request producing k results (1 to 3) holds the result register until all k are taken;
// one-result requests are taken every cycle while results are drained at once.
// Reset (arst_n low) clears all holds, levels, flags and the sensor mode at once.
// Depends on drbc_pkg, drbc_core and drbc_outq.
`timescale 1ns / 1ps

module door_relay_buzzer_controller #(
	parameter int unsigned TICK_MS       = 100,
	parameter int unsigned BEEP_HALF_MS  = 100,
	parameter int unsigned DEFAULT_BEEPS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [3:0]                      mode,
	input  logic [drbc_pkg::HOLD_W-1:0]     hold_ms,
	input  logic [drbc_pkg::PULSE_W-1:0]    beep_pulses,
	input  logic                            sensor_sample,
	output logic                            evt_valid,
	input  logic                            evt_ready,
	output logic [1:0]                      event_kind,
	output logic                            event_value,
	output logic                            relay_active,
	output logic                            buzzer_level,
	output logic                            qrcode_active,
	output logic                            alarm_flag,
	output logic                            panic_flag,
	output logic                            breakin_flag,
	output logic                            sensor_level,
	output logic                            last
);

	logic                           sensor_mode_q;
	logic                           valid_s1;
	logic [3:0]                     mode_s1;
	logic [drbc_pkg::HOLD_W-1:0]    hold_s1;
	logic [drbc_pkg::PULSE_W-1:0]   pulses_s1;
	logic                           sample_s1;
	logic                           load_ready, commit;
	drbc_pkg::bundle_t              bundle;
	drbc_pkg::result_t              res;

	assign commit    = valid_s1 && load_ready;
	assign cmd_ready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_mode_q <= 1'b0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				sensor_mode_q <= cfg_wdata;
			end
			if (cmd_valid && cmd_ready) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			mode_s1   <= mode;
			hold_s1   <= hold_ms;
			pulses_s1 <= beep_pulses;
			sample_s1 <= sensor_sample;
		end
	end

	drbc_core #(
		.TICK_MS       (TICK_MS),
		.BEEP_HALF_MS  (BEEP_HALF_MS),
		.DEFAULT_BEEPS (DEFAULT_BEEPS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.commit        (commit),
		.sensor_mode   (sensor_mode_q),
		.mode          (mode_s1),
		.hold_ms       (hold_s1),
		.beep_pulses   (pulses_s1),
		.sensor_sample (sample_s1),
		.bundle        (bundle)
	);

	drbc_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_ready  (load_ready),
		.load_bundle (bundle),
		.out_valid   (evt_valid),
		.out_ready   (evt_ready),
		.out_result  (res),
		.out_last    (last)
	);

	assign event_kind    = res.kind;
	assign event_value   = res.value;
	assign relay_active  = res.status.relay;
	assign buzzer_level  = res.status.buzzer;
	assign qrcode_active = res.status.qrcode;
	assign alarm_flag    = res.status.alarm;
	assign panic_flag    = res.status.panic;
	assign breakin_flag  = res.status.breakin;
	assign sensor_level  = res.status.sensor;

endmodule

[sim/door_relay_buzzer_controller_test.sv]
// Self-checking testbench for door_relay_buzzer_controller: directed and random requests,
// each checked against a typed result or a predictor of relay, buzzer, beep and sensor.
// Depends on drbc_pkg and the door_relay_buzzer_controller RTL.
`timescale 1ns / 1ps

module door_relay_buzzer_controller_test;

	localparam int unsigned TICK_MS       = 100;
	localparam int unsigned BEEP_HALF_MS  = 100;
	localparam int unsigned DEFAULT_BEEPS = 3;
	localparam logic [3:0]  MODE_UNUSED   = 4'd15;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          HOLDOFF_LEN   = 200;
	localparam int          NUM_DIRECTED  = 26;
	localparam int          PHASE_ITEMS   = 26;

	typedef struct packed {
		drbc_pkg::result_t res;
		logic              last;
	} evt_rec_t;

	typedef struct packed {
		logic [3:0]                   mode;
		logic [drbc_pkg::HOLD_W-1:0]  hold;
		logic [drbc_pkg::PULSE_W-1:0] pulses;
		logic                         sample;
		bit                           typed;
		evt_rec_t                     want;
	} stim_row_t;

	localparam evt_rec_t NO_WANT = '0;

	// Rows with typed results start from a state that is obvious by inspection.
	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{MODE_UNUSED, 24'hFFFFFF, 7'h7F, 1'b1, 1'b1,
			'{'{drbc_pkg::EV_NONE, 1'b0, 7'b0000000}, 1'b1}},
		'{drbc_pkg::MODE_TICK, 24'd0, 7'd0, 1'b0, 1'b1,
			'{'{drbc_pkg::EV_NONE, 1'b0, 7'b0000000}, 1'b1}},
		'{drbc_pkg::MODE_RELAY_ON, 24'hFFFFFF, 7'd0, 1'b0, 1'b1,
			'{'{drbc_pkg::EV_RELAY, 1'b1, 7'b1000000}, 1'b1}},
		'{drbc_pkg::MODE_BUZZER_ON, 24'd150, 7'd0, 1'b0, 1'b1,
			'{'{drbc_pkg::EV_BUZZER, 1'b1, 7'b1100000}, 1'b1}},
		'{drbc_pkg::MODE_TICK, 24'd0, 7'd0, 1'b1, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_TICK, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_RELAY_OFF, 24'd0, 7'd0, 1'b0, 1'b1,
			'{'{drbc_pkg::EV_RELAY, 1'b0, 7'b0000000}, 1'b1}},
		'{drbc_pkg::MODE_RELAY_ON, 24'd1, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BUZZER_ON, 24'd100, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_TICK, 24'd0, 7'd0, 1'b1, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BUZZER_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_TICK, 24'd0, 7'd0, 1'b1, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_ALARM_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_ALARM_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BREAKIN_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_ALARM_OFF, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BREAKIN_OFF, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_PANIC_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_PANIC_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_PANIC_OFF, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_QR_ON, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_SENSOR_EDGE, 24'd0, 7'd0, 1'b1, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BEEP, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BEEP, 24'd0, 7'h7F, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_QR_OFF, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT},
		'{drbc_pkg::MODE_BUZZER_OFF, 24'd0, 7'd0, 1'b0, 1'b0, NO_WANT}
	};

	localparam string FIELD_NAME [10] = '{"event_kind", "event_value", "relay_active",
		"buzzer_level", "qrcode_active", "alarm_flag", "panic_flag", "breakin_flag",
		"sensor_level", "last"};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic                         cfg_wdata = 1'b0;
	logic                         cmd_valid = 1'b0;
	logic                         cmd_ready;
	logic [3:0]                   mode = '0;
	logic [drbc_pkg::HOLD_W-1:0]  hold_ms = '0;
	logic [drbc_pkg::PULSE_W-1:0] beep_pulses = '0;
	logic                         sensor_sample = 1'b0;
	logic                         evt_valid;
	logic                         evt_ready = 1'b0;
	logic [1:0]                   event_kind;
	logic                         event_value;
	logic                         relay_active;
	logic                         buzzer_level;
	logic                         qrcode_active;
	logic                         alarm_flag;
	logic                         panic_flag;
	logic                         breakin_flag;
	logic                         sensor_level;
	logic                         last;

	// Predicted controller state.
	drbc_pkg::status_t            ctl_status;
	logic [drbc_pkg::HOLD_W-1:0]  relay_left;
	logic [drbc_pkg::HOLD_W-1:0]  buzzer_left;
	logic [drbc_pkg::HOLD_W-1:0]  beep_left;
	logic [drbc_pkg::PHASE_W-1:0] beep_halves;
	logic                         edge_mode;

	evt_rec_t           step_events [drbc_pkg::MAX_RES];
	int                 step_count;
	evt_rec_t           awaited_events [$];

	int                 mismatches = 0;
	int                 quiet_cycles = 0;
	int                 sender_idle_pct = 0;
	int                 stall_pct = 0;
	bit                 holdoff_req = 1'b0;
	bit                 holdoff_ack = 1'b0;
	int                 holdoff_left = 0;

	door_relay_buzzer_controller #(
		.TICK_MS(TICK_MS),
		.BEEP_HALF_MS(BEEP_HALF_MS),
		.DEFAULT_BEEPS(DEFAULT_BEEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.mode(mode),
		.hold_ms(hold_ms),
		.beep_pulses(beep_pulses),
		.sensor_sample(sensor_sample),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.event_kind(event_kind),
		.event_value(event_value),
		.relay_active(relay_active),
		.buzzer_level(buzzer_level),
		.qrcode_active(qrcode_active),
		.alarm_flag(alarm_flag),
		.panic_flag(panic_flag),
		.breakin_flag(breakin_flag),
		.sensor_level(sensor_level),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [drbc_pkg::HOLD_W-1:0] tick_down(
		logic [drbc_pkg::HOLD_W-1:0] v);
		return (v > TICK_MS) ? v - drbc_pkg::HOLD_W'(TICK_MS) : '0;
	endfunction

	function automatic void note_event(drbc_pkg::event_t k, logic v);
		step_events[step_count] = '{'{k, v, ctl_status}, 1'b0};
		step_count++;
	endfunction

	function automatic void drive_relay(logic on, logic [drbc_pkg::HOLD_W-1:0] h);
		ctl_status.relay = on;
		relay_left = on ? h : '0;
		note_event(drbc_pkg::EV_RELAY, on);
	endfunction

	function automatic void drive_buzzer(logic on, logic [drbc_pkg::HOLD_W-1:0] h);
		ctl_status.buzzer = on;
		buzzer_left = on ? h : '0;
		note_event(drbc_pkg::EV_BUZZER, on);
	endfunction

	// Works out the results of one request and advances the predicted state.
	function automatic void compute_events(logic [3:0] m, logic [drbc_pkg::HOLD_W-1:0] h,
		logic [drbc_pkg::PULSE_W-1:0] bp, logic s);
		step_count = 0;
		case (m)
			drbc_pkg::MODE_TICK: begin
				if (!edge_mode && ctl_status.sensor != s) begin
					ctl_status.sensor = s;
					note_event(drbc_pkg::EV_SENSOR, s);
				end
				if (relay_left != 0) begin
					relay_left = tick_down(relay_left);
					if (relay_left == 0)
						drive_relay(1'b0, '0);
				end
				if (buzzer_left != 0) begin
					buzzer_left = tick_down(buzzer_left);
					if (buzzer_left == 0)
						drive_buzzer(1'b0, '0);
				end
				// The beep generator toggles the buzzer silently.
				if (beep_left != 0) begin
					beep_left = tick_down(beep_left);
					if (beep_left == 0) begin
						beep_halves = beep_halves - 1'b1;
						ctl_status.buzzer = beep_halves[0];
						if (beep_halves != 0)
							beep_left = drbc_pkg::HOLD_W'(BEEP_HALF_MS);
					end
				end
			end
			drbc_pkg::MODE_RELAY_ON: drive_relay(1'b1, h);
			drbc_pkg::MODE_RELAY_OFF: drive_relay(1'b0, '0);
			drbc_pkg::MODE_BUZZER_ON: drive_buzzer(1'b1, h);
			drbc_pkg::MODE_BUZZER_OFF: drive_buzzer(1'b0, '0);
			drbc_pkg::MODE_ALARM_ON: begin
				if (!ctl_status.alarm) begin
					ctl_status.alarm = 1'b1;
					drive_buzzer(1'b1, '0);
				end
			end
			drbc_pkg::MODE_ALARM_OFF: begin
				if (ctl_status.alarm) begin
					ctl_status.alarm = 1'b0;
					ctl_status.breakin = 1'b0;
					drive_buzzer(1'b0, '0);
				end
			end
			drbc_pkg::MODE_PANIC_ON: begin
				if (!ctl_status.panic) begin
					ctl_status.panic = 1'b1;
					drive_relay(1'b1, '0);
				end
			end
			drbc_pkg::MODE_PANIC_OFF: begin
				if (ctl_status.panic) begin
					ctl_status.panic = 1'b0;
					drive_relay(1'b0, '0);
				end
			end
			drbc_pkg::MODE_BREAKIN_ON: begin
				if (!ctl_status.breakin) begin
					ctl_status.breakin = 1'b1;
					ctl_status.alarm = 1'b1;
					drive_buzzer(1'b1, '0);
				end
			end
			drbc_pkg::MODE_BREAKIN_OFF: begin
				if (ctl_status.breakin) begin
					ctl_status.breakin = 1'b0;
					ctl_status.alarm = 1'b0;
					drive_buzzer(1'b0, '0);
				end
			end
			drbc_pkg::MODE_BEEP: begin
				ctl_status.buzzer = 1'b1;
				beep_left = drbc_pkg::HOLD_W'(BEEP_HALF_MS);
				beep_halves = drbc_pkg::PHASE_W'(
					((bp != 0) ? int'(bp) : DEFAULT_BEEPS) << 1);
			end
			drbc_pkg::MODE_SENSOR_EDGE: begin
				if (edge_mode)
					note_event(drbc_pkg::EV_SENSOR, 1'b0);
			end
			drbc_pkg::MODE_QR_ON: ctl_status.qrcode = 1'b1;
			drbc_pkg::MODE_QR_OFF: ctl_status.qrcode = 1'b0;
			default: ;
		endcase
		if (step_count == 0)
			note_event(drbc_pkg::EV_NONE, 1'b0);
		step_events[step_count-1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Offers one request, holds it until taken, then records its expected results.
	task automatic send_req(logic [3:0] m, logic [drbc_pkg::HOLD_W-1:0] h,
		logic [drbc_pkg::PULSE_W-1:0] bp, logic s, bit typed, evt_rec_t want);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		mode <= m;
		hold_ms <= h;
		beep_pulses <= bp;
		sensor_sample <= s;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		compute_events(m, h, bp, s);
		if (typed) begin
			step_events[0] = want;
			step_count = 1;
		end
		for (int k = 0; k < step_count; k++)
			awaited_events.push_back(step_events[k]);
	endtask

	task automatic random_req();
		logic [3:0]                   m;
		logic [drbc_pkg::HOLD_W-1:0]  h;
		logic [drbc_pkg::PULSE_W-1:0] bp;
		int                           pick;
		pick = $urandom_range(99);
		m = (pick < 40) ? drbc_pkg::MODE_TICK : 4'($urandom_range(15, 1));
		pick = $urandom_range(99);
		if (pick < 10)
			h = '0;
		else if (pick < 20)
			h = drbc_pkg::HOLD_W'($urandom);
		else
			h = drbc_pkg::HOLD_W'($urandom_range(600));
		bp = ($urandom_range(99) < 70) ? drbc_pkg::PULSE_W'($urandom_range(4))
			: drbc_pkg::PULSE_W'($urandom);
		send_req(m, h, bp, 1'($urandom_range(1)), 1'b0, NO_WANT);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sensor_mode(logic v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		edge_mode = v;
	endtask

	always @(posedge clk) begin
		if (holdoff_req != holdoff_ack) begin
			holdoff_ack <= holdoff_req;
			holdoff_left <= HOLDOFF_LEN;
			evt_ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			evt_ready <= 1'b0;
		end else begin
			evt_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		evt_rec_t want;
		int       got_f [10];
		int       want_f [10];
		if (arst_n && evt_valid && evt_ready) begin
			if (awaited_events.size() == 0) begin
				report_mismatch("unawaited result, event_kind", int'(event_kind), -1);
			end else begin
				want = awaited_events.pop_front();
				got_f = '{int'(event_kind), int'(event_value), int'(relay_active),
					int'(buzzer_level), int'(qrcode_active), int'(alarm_flag),
					int'(panic_flag), int'(breakin_flag), int'(sensor_level), int'(last)};
				want_f = '{int'(want.res.kind), int'(want.res.value),
					int'(want.res.status.relay), int'(want.res.status.buzzer),
					int'(want.res.status.qrcode), int'(want.res.status.alarm),
					int'(want.res.status.panic), int'(want.res.status.breakin),
					int'(want.res.status.sensor), int'(want.last)};
				for (int k = 0; k < 10; k++)
					if (got_f[k] != want_f[k])
						report_mismatch(FIELD_NAME[k], got_f[k], want_f[k]);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (evt_valid && evt_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $realtime,
					STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		ctl_status = '0;
		relay_left = '0;
		buzzer_left = '0;
		beep_left = '0;
		beep_halves = '0;
		edge_mode = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_sensor_mode(1'b0);
		for (int r = 0; r < NUM_DIRECTED; r++)
			send_req(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].hold, DIRECTED_ROWS[r].pulses,
				DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		// Phases: no idling, sender idle, receiver stalling, both; sensor mode alternates.
		for (int p = 0; p < 4; p++) begin
			set_sensor_mode(p % 2 == 0);
			sender_idle_pct = (p == 1) ? 56 : (p == 3) ? 27 : 0;
			stall_pct <= (p == 2) ? 56 : (p == 3) ? 27 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// A long receiver hold-off while requests keep coming fills the block.
				if (p == 0 && i == 8)
					holdoff_req <= ~holdoff_req;
				if (p == 2 && i == 13)
					wait_drained();
				random_req();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[door_relay_buzzer_controller.f]
hdl/drbc_pkg.sv
hdl/drbc_core.sv
hdl/drbc_outq.sv
hdl/door_relay_buzzer_controller.sv
sim/door_relay_buzzer_controller_test.sv
